// ===== rtl/hafe_pkg.sv =====
// Shared types, frame constants and the hex digit encoder for the hex ASCII frame encoder.
// Standalone package; used by every module of the block.
`timescale 1ns / 1ps

package hafe_pkg;

    // Frame layout
    localparam int HDR_LEN     = 4;
    localparam int HEX_DIGITS  = 22;
    localparam int FRAME_LEN   = HDR_LEN + HEX_DIGITS + 1;
    localparam int IDX_W       = $clog2(FRAME_LEN);
    localparam int REC_W       = 4 * HEX_DIGITS;

    localparam logic [IDX_W-1:0] IDX_HEX_FIRST = IDX_W'(HDR_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(FRAME_LEN - 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Characters
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_5       = 8'h35;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_HEX_OFS = 8'h37;

    // One classified record: payload bytes plus checksum, in send order
    typedef struct packed {
        logic        [7:0]  cmd;
        logic        [15:0] id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic        [7:0]  err;
        logic        [7:0]  sum;
    } t_rec;

    // Map a nibble to its uppercase ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CHAR_ZERO + {4'h0, nib};
        end else begin
            r = CHAR_HEX_OFS + {4'h0, nib};
        end
        return r;
    endfunction

endpackage

// ===== rtl/hafe_front.sv =====
// Front stage: accepts command records and forms the modulo-256 checksum.
// Depends on hafe_pkg; feeds hafe_queue.
`timescale 1ns / 1ps

module hafe_front
    import hafe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [7:0]  i_command_code,
    input  logic        [15:0] i_target_id,
    input  logic signed [15:0] i_pos_x_mm,
    input  logic signed [15:0] i_pos_y_mm,
    input  logic signed [15:0] i_pos_z_mm,
    input  logic        [7:0]  i_error_code,
    output logic               o_rec_valid,
    input  logic               i_rec_ready,
    output t_rec               o_rec
);

    logic       r_valid;
    t_rec       r_rec;
    t_rec       n_rec;
    logic [7:0] w_sum;

    // Sum the ten payload bytes, wrapping at 8 bits
    assign w_sum = i_command_code
                 + i_target_id[15:8] + i_target_id[7:0]
                 + i_pos_x_mm[15:8] + i_pos_x_mm[7:0]
                 + i_pos_y_mm[15:8] + i_pos_y_mm[7:0]
                 + i_pos_z_mm[15:8] + i_pos_z_mm[7:0]
                 + i_error_code;

    always_comb begin
        n_rec.cmd = i_command_code;
        n_rec.id  = i_target_id;
        n_rec.x   = i_pos_x_mm;
        n_rec.y   = i_pos_y_mm;
        n_rec.z   = i_pos_z_mm;
        n_rec.err = i_error_code;
        n_rec.sum = w_sum;
    end

    // Take a new word whenever the holding register is empty or draining
    assign o_ready     = !r_valid || i_rec_ready;
    assign o_rec_valid = r_valid;
    assign o_rec       = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_rec_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload until a new word arrives
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rec <= n_rec;
        end
    end

endmodule

// ===== rtl/hafe_queue.sv =====
// Short record queue that decouples the front stage from the serializer.
// Depends on hafe_pkg for the record type and depth.
`timescale 1ns / 1ps

module hafe_queue
    import hafe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_not_full,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_not_empty,
    output t_rec o_rec
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_not_full  = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_rec       = r_mem[r_rptr];
    assign w_wr        = i_push && o_not_full;
    assign w_rd        = i_pop && o_not_empty;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

// ===== rtl/hafe_back.sv =====
// Back stage: serializes one record into the 27-character ASCII frame.
// Depends on hafe_pkg; pulls records from hafe_queue.
`timescale 1ns / 1ps

module hafe_back
    import hafe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rec_valid,
    output logic       o_rec_pop,
    input  t_rec       i_rec,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_ascii_char,
    output logic       o_frame_end
);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [REC_W-1:0] r_shift;
    logic             w_take;
    logic             w_last;
    logic             w_is_hex;

    assign w_last   = r_idx == IDX_LAST;
    assign w_take   = r_busy && i_ready;
    assign w_is_hex = (r_idx >= IDX_HEX_FIRST) && !w_last;

    // Load the next record when idle or as the newline leaves
    assign o_rec_pop = i_rec_valid && (!r_busy || (w_take && w_last));

    // Pick the current character
    always_comb begin
        if (w_last) begin
            o_ascii_char = CHAR_NL;
        end else if (w_is_hex) begin
            o_ascii_char = hex_char(r_shift[REC_W-1 -: 4]);
        end else if (r_idx[1]) begin
            o_ascii_char = CHAR_5;
        end else begin
            o_ascii_char = CHAR_A;
        end
    end

    assign o_valid     = r_busy;
    assign o_frame_end = r_busy && w_last;

    // Step through the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_rec_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Shift out one nibble per hex digit, high nibble first
    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_shift <= REC_W'(i_rec);
        end else if (w_take && w_is_hex) begin
            r_shift <= {r_shift[REC_W-5:0], 4'h0};
        end
    end

    // Pop only when the queue has a word
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_pop |-> i_rec_valid)
        else $error("record popped from empty queue");

    // After the newline leaves, the next frame starts at its header
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_frame_end) |=> (r_idx == '0))
        else $error("frame did not restart at header");

    // No bubble inside a frame
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_frame_end) |=> o_valid)
        else $error("gap inside frame");

endmodule

// ===== rtl/hex_ascii_frame_encoder_top.sv =====
// Top level of the hex ASCII frame encoder: front stage, record queue, serializer.
// Depends on hafe_pkg, hafe_front, hafe_queue and hafe_back.
// The first character appears once a record has passed the front register, the queue and the serializer.
// The serializer sends one character per cycle while i_ready is high.
// Frames follow each other with no idle cycle while records are queued.
// Reset (synchronous, active low) empties the front register, queue and serializer.
`timescale 1ns / 1ps

module hex_ascii_frame_encoder_top
    import hafe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [7:0]  i_command_code,
    input  logic        [15:0] i_target_id,
    input  logic signed [15:0] i_pos_x_mm,
    input  logic signed [15:0] i_pos_y_mm,
    input  logic signed [15:0] i_pos_z_mm,
    input  logic        [7:0]  i_error_code,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [7:0]  o_ascii_char,
    output logic               o_frame_end
);

    logic w_front_valid;
    logic w_q_not_full;
    t_rec w_front_rec;
    logic w_q_not_empty;
    logic w_pop;
    t_rec w_q_rec;

    hafe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command_code (i_command_code),
        .i_target_id    (i_target_id),
        .i_pos_x_mm     (i_pos_x_mm),
        .i_pos_y_mm     (i_pos_y_mm),
        .i_pos_z_mm     (i_pos_z_mm),
        .i_error_code   (i_error_code),
        .o_rec_valid    (w_front_valid),
        .i_rec_ready    (w_q_not_full),
        .o_rec          (w_front_rec)
    );

    hafe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_front_valid),
        .o_not_full  (w_q_not_full),
        .i_rec       (w_front_rec),
        .i_pop       (w_pop),
        .o_not_empty (w_q_not_empty),
        .o_rec       (w_q_rec)
    );

    hafe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (w_q_not_empty),
        .o_rec_pop    (w_pop),
        .i_rec        (w_q_rec),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_frame_end  (o_frame_end)
    );

endmodule
